@@ sv/vlr_pkg.sv @@
package vlr_pkg;

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 10;
  localparam int POS_W   = 18;
  localparam int CELL_W  = 10;
  localparam int CFG_W   = 11;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 21;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELAX = 2'd2;

  localparam logic [CFG_W-1:0] SEED_COUNT_RESET = 11'd2;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic load_wr;
    logic scan_start;
    logic acc_rd;
    logic acc_wr_q;
    logic out_load;
    logic ridx_clr;
    logic ridx_inc;
    logic rlx_rd;
    logic zero_wr;
    logic div_start;
    logic seed_wr_rlx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic ridx_last;
    logic cnt_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ sv/vlr_chan_if.sv @@
interface vlr_in_if;
  logic                        valid;
  logic                        ready;
  logic [vlr_pkg::KIND_W-1:0]  kind;
  logic [vlr_pkg::INDEX_W-1:0] seed_index;
  logic [vlr_pkg::POS_W-1:0]   seed_x;
  logic [vlr_pkg::POS_W-1:0]   seed_y;
  logic [vlr_pkg::CELL_W-1:0]  cell_x;
  logic [vlr_pkg::CELL_W-1:0]  cell_y;

  modport source(output valid, kind, seed_index, seed_x, seed_y, cell_x, cell_y,
                 input ready);
  modport sink(input valid, kind, seed_index, seed_x, seed_y, cell_x, cell_y,
               output ready);
endinterface

interface vlr_out_if;
  logic                        valid;
  logic                        ready;
  logic [vlr_pkg::INDEX_W-1:0] nearest_seed;

  modport source(output valid, nearest_seed, input ready);
  modport sink(input valid, nearest_seed, output ready);
endinterface

@@ sv/vlr_div.sv @@
module vlr_div #(
  parameter int NW = 41
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NW-1:0]              num_x,
  input  logic [NW-1:0]              num_y,
  input  logic [vlr_pkg::CNT_W-1:0]  den,
  output logic                       done,
  output logic [vlr_pkg::POS_W-1:0]  q_x,
  output logic [vlr_pkg::POS_W-1:0]  q_y
);

  localparam int CW = $clog2(NW + 1);
  localparam int RW = vlr_pkg::CNT_W;
  localparam int PW = vlr_pkg::POS_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [RW-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [RW-1:0] den_r;
  logic [RW:0]   tx, ty;

  // one restoring step per cycle, quotient shifts in as the numerator shifts out
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    nx_nxt   = nx_r;
    ny_nxt   = ny_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    tx       = {rx_r, nx_r[NW-1]};
    ty       = {ry_r, ny_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      nx_nxt   = num_x;
      ny_nxt   = num_y;
      rx_nxt   = '0;
      ry_nxt   = '0;
    end else if (busy_r) begin
      if (tx >= {1'b0, den_r}) begin
        rx_nxt = RW'(tx - {1'b0, den_r});
        nx_nxt = {nx_r[NW-2:0], 1'b1};
      end else begin
        rx_nxt = RW'(tx);
        nx_nxt = {nx_r[NW-2:0], 1'b0};
      end
      if (ty >= {1'b0, den_r}) begin
        ry_nxt = RW'(ty - {1'b0, den_r});
        ny_nxt = {ny_r[NW-2:0], 1'b1};
      end else begin
        ry_nxt = RW'(ty);
        ny_nxt = {ny_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    rx_r  <= rx_nxt;
    ry_r  <= ry_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign q_x  = (|nx_r[NW-1:PW]) ? '1 : nx_r[PW-1:0];
  assign q_y  = (|ny_r[NW-1:PW]) ? '1 : ny_r[PW-1:0];

endmodule

@@ sv/vlr_datapath.sv @@
module vlr_datapath #(
  parameter int MAX_SEEDS       = 1024,
  parameter int GRID_SIDE       = 1024,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vlr_pkg::cmd_t                cmd,
  output vlr_pkg::sts_t                sts,
  input  logic                         cfg_we,
  input  logic [vlr_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [vlr_pkg::INDEX_W-1:0]  in_seed_index,
  input  logic [vlr_pkg::POS_W-1:0]    in_seed_x,
  input  logic [vlr_pkg::POS_W-1:0]    in_seed_y,
  input  logic [vlr_pkg::CELL_W-1:0]   in_cell_x,
  input  logic [vlr_pkg::CELL_W-1:0]   in_cell_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vlr_pkg::INDEX_W-1:0]  out_nearest_seed
);

  localparam int AW   = $clog2(MAX_SEEDS);
  localparam int F    = COORD_FRAC_BITS;
  localparam int PSW  = vlr_pkg::POS_W;
  localparam int CLW  = vlr_pkg::CELL_W;
  localparam int SW   = vlr_pkg::SUM_W;
  localparam int NCW  = vlr_pkg::CNT_W;
  localparam int PW   = CLW + F;
  localparam int DW   = (PW > PSW) ? PW : PSW;
  localparam int SQW  = 2 * DW;
  localparam int DSW  = SQW + 1;
  localparam int NW   = SW + F + 1;

  // tables
  logic [PSW-1:0] sx_mem   [MAX_SEEDS];
  logic [PSW-1:0] sy_mem   [MAX_SEEDS];
  logic [SW-1:0]  sumx_mem [MAX_SEEDS];
  logic [SW-1:0]  sumy_mem [MAX_SEEDS];
  logic [NCW-1:0] cnt_mem  [MAX_SEEDS];

  logic [vlr_pkg::CFG_W-1:0] seed_count_r;
  logic [AW-1:0]  n_last;
  logic [CLW-1:0] cx_clamp, cy_clamp;
  logic [CLW-1:0] cx_r, cy_r;
  logic [PW-1:0]  px_r, py_r;

  // scan pipeline
  logic           issue_r;
  logic [AW-1:0]  sidx_r;
  logic           v1_r, v2_r, v3_r, done_r;
  logic           last1_r, last2_r, last3_r;
  logic [AW-1:0]  idx1_r, idx2_r, idx3_r;
  logic [PSW-1:0] sx_rd_r, sy_rd_r;
  logic [DW-1:0]  sxe, sye, pxe, pye;
  logic [DW-1:0]  adx_r, ady_r;
  logic [SQW-1:0] sqx_r, sqy_r;
  logic [DSW-1:0] dist_sum;
  logic [DSW-1:0] best_d_r;
  logic [AW-1:0]  best_r;

  // accumulators and sweep
  logic [AW-1:0]  ridx_r;
  logic [SW-1:0]  sumx_rd_r, sumy_rd_r;
  logic [NCW-1:0] cnt_rd_r;
  logic           acc_we, acc_re;
  logic [AW-1:0]  acc_wa, acc_ra;
  logic [SW-1:0]  acc_wx, acc_wy;
  logic [NCW-1:0] acc_wc;
  logic [SW:0]    sat_x, sat_y;

  logic           seed_we, load_ok;
  logic [AW-1:0]  seed_wa;
  logic [PSW-1:0] seed_wx, seed_wy;

  logic [NW-1:0]  num_x, num_y;
  logic           div_done;
  logic [PSW-1:0] q_x, q_y;

  logic                        out_v_r;
  logic [vlr_pkg::INDEX_W-1:0] out_seed_r;

  // seed count clamped to 2..MAX_SEEDS for the scan
  always_comb begin
    if (seed_count_r < vlr_pkg::CFG_W'(2)) begin
      n_last = AW'(1);
    end else if (32'(seed_count_r) > MAX_SEEDS) begin
      n_last = AW'(MAX_SEEDS - 1);
    end else begin
      n_last = AW'(seed_count_r - vlr_pkg::CFG_W'(1));
    end
  end

  assign cx_clamp = (32'(in_cell_x) >= GRID_SIDE) ? CLW'(GRID_SIDE - 1) : in_cell_x;
  assign cy_clamp = (32'(in_cell_y) >= GRID_SIDE) ? CLW'(GRID_SIDE - 1) : in_cell_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_count_r <= vlr_pkg::SEED_COUNT_RESET;
    end else if (cfg_we) begin
      seed_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cx_r <= cx_clamp;
      cy_r <= cy_clamp;
      px_r <= (PW'(cx_clamp) << F) + (PW'(1) << (F - 1));
      py_r <= (PW'(cy_clamp) << F) + (PW'(1) << (F - 1));
    end
  end

  // seed tables: written by loads and by relax, read by the scan
  assign load_ok = 32'(in_seed_index) < MAX_SEEDS;
  assign seed_we = (cmd.load_wr && load_ok) || cmd.seed_wr_rlx;
  assign seed_wa = cmd.load_wr ? AW'(in_seed_index) : ridx_r;
  assign seed_wx = cmd.load_wr ? in_seed_x : q_x;
  assign seed_wy = cmd.load_wr ? in_seed_y : q_y;

  always_ff @(posedge clk) begin
    if (seed_we) begin
      sx_mem[seed_wa] <= seed_wx;
      sy_mem[seed_wa] <= seed_wy;
    end
    if (issue_r) begin
      sx_rd_r <= sx_mem[sidx_r];
      sy_rd_r <= sy_mem[sidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      sidx_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        issue_r <= 1'b1;
        sidx_r  <= '0;
      end else if (issue_r) begin
        if (sidx_r == n_last) begin
          issue_r <= 1'b0;
        end
        sidx_r <= sidx_r + AW'(1);
      end
      v1_r   <= issue_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r && last3_r;
    end
  end

  assign sxe      = DW'(sx_rd_r);
  assign sye      = DW'(sy_rd_r);
  assign pxe      = DW'(px_r);
  assign pye      = DW'(py_r);
  assign dist_sum = DSW'(sqx_r) + DSW'(sqy_r);

  always_ff @(posedge clk) begin
    idx1_r  <= sidx_r;
    last1_r <= sidx_r == n_last;
    idx2_r  <= idx1_r;
    last2_r <= last1_r;
    adx_r   <= (sxe > pxe) ? sxe - pxe : pxe - sxe;
    ady_r   <= (sye > pye) ? sye - pye : pye - sye;
    idx3_r  <= idx2_r;
    last3_r <= last2_r;
    sqx_r   <= SQW'(adx_r) * SQW'(adx_r);
    sqy_r   <= SQW'(ady_r) * SQW'(ady_r);
    // strict compare keeps the lowest index on a tie
    if (v3_r && (idx3_r == '0 || dist_sum < best_d_r)) begin
      best_d_r <= dist_sum;
      best_r   <= idx3_r;
    end
  end

  // accumulators
  assign sat_x  = {1'b0, sumx_rd_r} + (SW + 1)'(cx_r);
  assign sat_y  = {1'b0, sumy_rd_r} + (SW + 1)'(cy_r);
  assign acc_re = cmd.acc_rd || cmd.rlx_rd;
  assign acc_ra = cmd.acc_rd ? best_r : ridx_r;
  assign acc_we = cmd.acc_wr_q || cmd.zero_wr;
  assign acc_wa = cmd.acc_wr_q ? best_r : ridx_r;

  always_comb begin
    acc_wx = '0;
    acc_wy = '0;
    acc_wc = '0;
    if (cmd.acc_wr_q) begin
      acc_wx = sat_x[SW] ? '1 : sat_x[SW-1:0];
      acc_wy = sat_y[SW] ? '1 : sat_y[SW-1:0];
      acc_wc = (&cnt_rd_r) ? cnt_rd_r : cnt_rd_r + NCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      sumx_mem[acc_wa] <= acc_wx;
      sumy_mem[acc_wa] <= acc_wy;
      cnt_mem[acc_wa]  <= acc_wc;
    end
    if (acc_re) begin
      sumx_rd_r <= sumx_mem[acc_ra];
      sumy_rd_r <= sumy_mem[acc_ra];
      cnt_rd_r  <= cnt_mem[acc_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ridx_r <= '0;
    end else if (cmd.ridx_clr) begin
      ridx_r <= '0;
    end else if (cmd.ridx_inc) begin
      ridx_r <= ridx_r + AW'(1);
    end
  end

  // centroid numerator: sum of cell centres in the fixed-point grid
  assign num_x = (NW'(sumx_rd_r) << F) + (NW'(cnt_rd_r) << (F - 1));
  assign num_y = (NW'(sumy_rd_r) << F) + (NW'(cnt_rd_r) << (F - 1));

  vlr_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num_x (num_x),
    .num_y (num_y),
    .den   (cnt_rd_r),
    .done  (div_done),
    .q_x   (q_x),
    .q_y   (q_y)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_seed_r <= vlr_pkg::INDEX_W'(best_r);
    end
  end

  assign out_valid        = out_v_r;
  assign out_nearest_seed = out_seed_r;

  assign sts.scan_done = done_r;
  assign sts.ridx_last = ridx_r == AW'(MAX_SEEDS - 1);
  assign sts.cnt_zero  = cnt_rd_r == '0;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_v_r || out_ready;

endmodule

@@ sv/vlr_ctrl.sv @@
module vlr_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [vlr_pkg::KIND_W-1:0] in_kind,
  output logic                       in_ready,
  output vlr_pkg::cmd_t              cmd,
  input  vlr_pkg::sts_t              sts
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_ACC_RD = 8'b0000_1000,
    S_ACC_WR = 8'b0001_0000,
    S_R_RD   = 8'b0010_0000,
    S_R_CHK  = 8'b0100_0000,
    S_R_DIV  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.latch = accept;
    unique case (state_r)
      S_CLEAR: begin
        cmd.zero_wr = 1'b1;
        if (sts.ridx_last) begin
          cmd.ridx_clr = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.ridx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            vlr_pkg::KIND_LOAD: cmd.load_wr = 1'b1;
            vlr_pkg::KIND_QUERY: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
            vlr_pkg::KIND_RELAX: begin
              cmd.ridx_clr = 1'b1;
              state_nxt    = S_R_RD;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_ACC_RD;
        end
      end
      S_ACC_RD: begin
        cmd.acc_rd = 1'b1;
        state_nxt  = S_ACC_WR;
      end
      S_ACC_WR: begin
        if (sts.out_free) begin
          cmd.acc_wr_q = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_R_RD: begin
        cmd.rlx_rd = 1'b1;
        state_nxt  = S_R_CHK;
      end
      S_R_CHK: begin
        if (sts.cnt_zero) begin
          cmd.zero_wr = 1'b1;
          if (sts.ridx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ridx_inc = 1'b1;
            state_nxt    = S_R_RD;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_R_DIV;
        end
      end
      S_R_DIV: begin
        if (sts.div_done) begin
          cmd.seed_wr_rlx = 1'b1;
          cmd.zero_wr     = 1'b1;
          if (sts.ridx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ridx_inc = 1'b1;
            state_nxt    = S_R_RD;
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/voronoi_assign_lloyd_relax_unit.sv @@
// Nearest-seed assignment with Lloyd relaxation. After reset the block clears its
// accumulators, one entry a cycle, through all MAX_SEEDS entries before it takes
// the first beat; configuration writes are taken all along. A load beat is written
// into the position tables as it is taken. A query reads the position tables one
// seed per cycle through a four-stage distance pipeline and then updates the
// winner's accumulators. A relax beat walks the whole table: an entry without
// members is read and cleared, and one with members is also moved to its centroid,
// formed by the one-bit-a-cycle divider (NW = 33 + COORD_FRAC_BITS bits). One
// beat is worked at a time; a finished result waits in its own register, so the
// next beat is taken while it is still unread.
module voronoi_assign_lloyd_relax_unit #(
  parameter int MAX_SEEDS       = 1024,
  parameter int GRID_SIDE       = 1024,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  vlr_in_if.sink                    in_ch,
  vlr_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [vlr_pkg::CFG_W-1:0] cfg_wdata
);

  vlr_pkg::cmd_t cmd;
  vlr_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  vlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  vlr_datapath #(
    .MAX_SEEDS       (MAX_SEEDS),
    .GRID_SIDE       (GRID_SIDE),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_seed_index    (in_ch.seed_index),
    .in_seed_x        (in_ch.seed_x),
    .in_seed_y        (in_ch.seed_y),
    .in_cell_x        (in_ch.cell_x),
    .in_cell_y        (in_ch.cell_y),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_nearest_seed (out_ch.nearest_seed)
  );

endmodule

@@ sv/vlr_checker.sv @@
module vlr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [vlr_pkg::KIND_W-1:0]  in_kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [vlr_pkg::INDEX_W-1:0] out_nearest_seed
);

  // the clearing pass keeps the input closed right after reset
  a_reset_closed: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open right after reset");

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == vlr_pkg::KIND_QUERY ||
     in_kind == vlr_pkg::KIND_RELAX)) |=> !in_ready)
    else $error("input open while a query or relax is at work");

  // a result appears only as the query finishes, when the input reopens
  a_result_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_nearest_seed)))
    else $error("stalled result changed");

endmodule

bind voronoi_assign_lloyd_relax_unit vlr_checker u_vlr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_kind          (in_ch.kind),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_nearest_seed (out_ch.nearest_seed)
);

@@ tb/sv/voronoi_assign_lloyd_relax_unit_test.sv @@
module voronoi_assign_lloyd_relax_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEED = 1024;
  localparam int FRAC = 8;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam logic [vlr_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [vlr_pkg::KIND_W-1:0]  kind;
    logic [vlr_pkg::INDEX_W-1:0] idx;
    logic [vlr_pkg::POS_W-1:0]   sx;
    logic [vlr_pkg::POS_W-1:0]   sy;
    logic [vlr_pkg::CELL_W-1:0]  cx;
    logic [vlr_pkg::CELL_W-1:0]  cy;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [vlr_pkg::CFG_W-1:0] cfg_wdata = '0;

  vlr_in_if in_ch();
  vlr_out_if out_ch();

  voronoi_assign_lloyd_relax_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  beat_t pending[$];
  logic [vlr_pkg::INDEX_W-1:0] nearest_q[$];
  bit written[NSEED];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit in_took = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int count_list[12] = '{3, 5, 8, 16, 0, 7, 33, 1, 12, 2, 64, 4};

  // block state copy
  logic [vlr_pkg::POS_W-1:0] pos_x[NSEED];
  logic [vlr_pkg::POS_W-1:0] pos_y[NSEED];
  logic [vlr_pkg::SUM_W-1:0] acc_x[NSEED];
  logic [vlr_pkg::SUM_W-1:0] acc_y[NSEED];
  logic [vlr_pkg::CNT_W-1:0] members[NSEED];
  logic [vlr_pkg::CFG_W-1:0] seed_cnt = vlr_pkg::SEED_COUNT_RESET;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.seed_index = '0;
    in_ch.seed_x = '0;
    in_ch.seed_y = '0;
    in_ch.cell_x = '0;
    in_ch.cell_y = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NSEED; i++) begin
      pos_x[i] = '0; pos_y[i] = '0; acc_x[i] = '0; acc_y[i] = '0; members[i] = '0;
    end
  end

  function automatic int eff_count(logic [vlr_pkg::CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > NSEED) return NSEED;
    return v;
  endfunction

  function automatic logic [vlr_pkg::POS_W-1:0] centroid_pos(
      logic [vlr_pkg::SUM_W-1:0] s, logic [vlr_pkg::CNT_W-1:0] c);
    longint unsigned num, q;
    num = (longint'(s) << FRAC) + (longint'(c) << (FRAC - 1));
    q = num / longint'(c);
    return (q > 64'h3FFFF) ? 18'h3FFFF : q[vlr_pkg::POS_W-1:0];
  endfunction

  function automatic logic [vlr_pkg::INDEX_W-1:0] find_nearest(
      logic [vlr_pkg::CELL_W-1:0] cx, logic [vlr_pkg::CELL_W-1:0] cy);
    longint unsigned px, py, dx, dy, d, best_d;
    int best, n;
    n = eff_count(seed_cnt);
    px = (longint'(cx) << FRAC) + (1 << (FRAC - 1));
    py = (longint'(cy) << FRAC) + (1 << (FRAC - 1));
    best = 0;
    best_d = 0;
    for (int i = 0; i < n; i++) begin
      dx = (pos_x[i] > px) ? pos_x[i] - px : px - pos_x[i];
      dy = (pos_y[i] > py) ? pos_y[i] - py : py - pos_y[i];
      d = dx * dx + dy * dy;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    return best[vlr_pkg::INDEX_W-1:0];
  endfunction

  task automatic apply_beat(beat_t b);
    logic [vlr_pkg::INDEX_W-1:0] w;
    longint unsigned t;
    case (b.kind)
      vlr_pkg::KIND_LOAD: begin
        pos_x[b.idx] = b.sx;
        pos_y[b.idx] = b.sy;
      end
      vlr_pkg::KIND_QUERY: begin
        w = find_nearest(b.cx, b.cy);
        t = longint'(acc_x[w]) + b.cx;
        acc_x[w] = (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[vlr_pkg::SUM_W-1:0];
        t = longint'(acc_y[w]) + b.cy;
        acc_y[w] = (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[vlr_pkg::SUM_W-1:0];
        if (members[w] != {vlr_pkg::CNT_W{1'b1}}) members[w] = members[w] + 1'b1;
        nearest_q.insert(nearest_q.size(), w);
      end
      vlr_pkg::KIND_RELAX: begin
        for (int i = 0; i < NSEED; i++) begin
          if (members[i] != 0) begin
            pos_x[i] = centroid_pos(acc_x[i], members[i]);
            pos_y[i] = centroid_pos(acc_y[i], members[i]);
          end
          acc_x[i] = '0; acc_y[i] = '0; members[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // monitor: prediction on input beats, checking on result beats
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      if (rst_n && cfg_we) seed_cnt = cfg_wdata;
      in_took <= rst_n && in_ch.valid && in_ch.ready;
      if (rst_n && in_ch.valid && in_ch.ready)
        apply_beat('{in_ch.kind, in_ch.seed_index, in_ch.seed_x, in_ch.seed_y,
                     in_ch.cell_x, in_ch.cell_y});
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (nearest_q.size() == 0) begin
          $error("nearest_seed: expected none, actual %0d", out_ch.nearest_seed);
          errors++;
        end else begin
          if (out_ch.nearest_seed !== nearest_q[0]) begin
            $error("nearest_seed: expected %0d, actual %0d", nearest_q[0],
                   out_ch.nearest_seed);
            errors++;
          end
          void'(nearest_q.pop_front());
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    beat_t b;
    if (rst_n) begin
      if (!in_ch.valid || in_took) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending.size() > 0) begin
          b = pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= b.kind;
          in_ch.seed_index <= b.idx;
          in_ch.seed_x <= b.sx;
          in_ch.seed_y <= b.sy;
          in_ch.cell_x <= b.cx;
          in_ch.cell_y <= b.cy;
          if (!quiet && $urandom_range(7) == 0) in_gap = $urandom_range(19, 1);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(9) == 0) begin
        out_gap = $urandom_range(19, 1) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic add_beat(beat_t b);
    pending.insert(pending.size(), b);
  endtask

  task automatic push_load(int i, logic [vlr_pkg::POS_W-1:0] x,
                           logic [vlr_pkg::POS_W-1:0] y);
    add_beat('{vlr_pkg::KIND_LOAD, i[vlr_pkg::INDEX_W-1:0], x, y,
               vlr_pkg::CELL_W'($urandom), vlr_pkg::CELL_W'($urandom)});
    written[i] = 1'b1;
  endtask

  task automatic push_query(logic [vlr_pkg::CELL_W-1:0] x, logic [vlr_pkg::CELL_W-1:0] y);
    add_beat('{vlr_pkg::KIND_QUERY, vlr_pkg::INDEX_W'($urandom),
               vlr_pkg::POS_W'($urandom), vlr_pkg::POS_W'($urandom), x, y});
  endtask

  task automatic push_other(logic [vlr_pkg::KIND_W-1:0] k);
    add_beat('{k, vlr_pkg::INDEX_W'($urandom), vlr_pkg::POS_W'($urandom),
               vlr_pkg::POS_W'($urandom), vlr_pkg::CELL_W'($urandom),
               vlr_pkg::CELL_W'($urandom)});
  endtask

  // a closing query makes sure no beat is still being worked when the queue drains
  task automatic drain();
    push_query(vlr_pkg::CELL_W'($urandom), vlr_pkg::CELL_W'($urandom));
    while (pending.size() > 0 || in_ch.valid || nearest_q.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_count(logic [vlr_pkg::CFG_W-1:0] v);
    int n;
    n = eff_count(v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    for (int i = 0; i < n; i++)
      if (!written[i]) push_load(i, vlr_pkg::POS_W'($urandom), vlr_pkg::POS_W'($urandom));
  endtask

  function automatic logic [vlr_pkg::POS_W-1:0] rand_pos();
    // coarse grid positions make equal distances common
    if ($urandom_range(2) == 0) return vlr_pkg::POS_W'($urandom_range(2047) * 128);
    return vlr_pkg::POS_W'($urandom);
  endfunction

  task automatic random_phase(int items);
    int n, r;
    n = eff_count(seed_cnt);
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      if (r < 55) push_query(vlr_pkg::CELL_W'($urandom), vlr_pkg::CELL_W'($urandom));
      else if (r < 85) push_load(($urandom_range(4) == 0) ? $urandom_range(NSEED - 1)
                                 : $urandom_range(n - 1), rand_pos(), rand_pos());
      else if (r < 93) push_other(vlr_pkg::KIND_RELAX);
      else push_other(KIND_UNUSED);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, ties, unknown kind, relax, clamping of the count
    push_load(0, '0, '0);
    push_load(1, {vlr_pkg::POS_W{1'b1}}, {vlr_pkg::POS_W{1'b1}});
    push_query('0, '0);
    push_query({vlr_pkg::CELL_W{1'b1}}, {vlr_pkg::CELL_W{1'b1}});
    push_query(10'd511, 10'd511);
    push_query(10'd512, 10'd512);
    push_load(1, '0, '0);
    push_query(10'd700, 10'd3);
    push_other(KIND_UNUSED);
    push_load(0, 18'd256, 18'd128);
    push_load(1, 18'd0, 18'd128);
    push_query(10'd0, 10'd0);
    push_query(10'd1, 10'd0);
    push_query(10'd0, 10'd9);
    push_other(vlr_pkg::KIND_RELAX);
    push_query(10'd0, 10'd0);
    push_other(vlr_pkg::KIND_RELAX);
    push_other(vlr_pkg::KIND_RELAX);
    push_query(10'd1000, 10'd20);
    set_count(11'd0);
    push_query(10'd5, 10'd5);

    foreach (count_list[c]) begin
      set_count(vlr_pkg::CFG_W'(count_list[c]));
      random_phase(37);
    end
    set_count(11'd6);
    drain();
    quiet = 1'b1;
    random_phase(37);
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
